/* rtl/core/sbd_pkg.sv */
// sbd_pkg: shared constants, function codes and controller/datapath structs
// for the splitter bucket distributor. No dependencies.
`timescale 1ns / 1ps

package sbd_pkg;

    localparam int MAX_BUCKETS_DEF = 256;
    localparam int COUNT_BITS_DEF  = 32;

    localparam int FUNC_W  = 3;
    localparam int KEY_W   = 64;
    localparam int IDX_W   = 8;
    localparam int BKT_W   = 8;
    localparam int OUT32_W = 32;
    localparam int CFG_W   = 9;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 136;

    localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd0;
    localparam logic [FUNC_W-1:0] FN_LOAD  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_CLASS = 3'd2;
    localparam logic [FUNC_W-1:0] FN_BUILD = 3'd3;
    localparam logic [FUNC_W-1:0] FN_SCAT  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_READ  = 3'd5;

    // controller -> datapath
    typedef struct packed {
        logic load_in;   // capture input item
        logic clr_init;  // restart clear sweep
        logic clr_step;  // zero one count entry
        logic spl_wr;    // write splitter slot
        logic srch_init; // lo/hi from active buckets
        logic srch_rd;   // read splitter at mid
        logic srch_upd;  // narrow lo/hi
        logic upd_rd;    // read count/offset at found bucket
        logic upd_wr;    // bump count or offset, set result
        logic bld_init;  // start prefix pass
        logic bld_rd;    // read count of current bucket
        logic bld_wr;    // write offset, accumulate
        logic rd_rd;     // read count/offset at index
        logic rd_res;    // set read result
        logic out_load;  // move result to output register
    } sbd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              clr_last;
        logic              srch_done;
        logic              bld_last;
        logic              out_free;
    } sbd_stat_t;

endpackage

/* rtl/core/sbd_ram.sv */
// sbd_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
`timescale 1ns / 1ps

module sbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/sbd_ctrl.sv */
// sbd_ctrl: sequencing state machine of the bucket distributor.
// Depends on sbd_pkg; drives the datapath by sbd_cmd_t only.
`timescale 1ns / 1ps

module sbd_ctrl
    import sbd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  sbd_stat_t stat,
    output sbd_cmd_t  cmd
);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_DEC    = 4'd2;
    localparam logic [3:0] ST_SRCH   = 4'd3;
    localparam logic [3:0] ST_SCMP   = 4'd4;
    localparam logic [3:0] ST_UPD_RD = 4'd5;
    localparam logic [3:0] ST_UPD_WR = 4'd6;
    localparam logic [3:0] ST_BLD_RD = 4'd7;
    localparam logic [3:0] ST_BLD_WR = 4'd8;
    localparam logic [3:0] ST_RD_RD  = 4'd9;
    localparam logic [3:0] ST_RD_RES = 4'd10;
    localparam logic [3:0] ST_FIN    = 4'd11;

    logic [3:0] state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DEC;
                end
            end
            ST_DEC:
            begin
                case (stat.func)
                    FN_CLEAR:
                    begin
                        cmd.clr_init = 1'b1;
                        state_next   = ST_CLEAR;
                    end
                    FN_LOAD:
                    begin
                        cmd.spl_wr = 1'b1;
                        state_next = ST_IDLE;
                    end
                    FN_CLASS, FN_SCAT:
                    begin
                        cmd.srch_init = 1'b1;
                        state_next    = ST_SRCH;
                    end
                    FN_BUILD:
                    begin
                        cmd.bld_init = 1'b1;
                        state_next   = ST_BLD_RD;
                    end
                    FN_READ:
                    begin
                        state_next = ST_RD_RD;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SRCH:
            begin
                if (stat.srch_done)
                begin
                    state_next = ST_UPD_RD;
                end
                else
                begin
                    cmd.srch_rd = 1'b1;
                    state_next  = ST_SCMP;
                end
            end
            ST_SCMP:
            begin
                cmd.srch_upd = 1'b1;
                state_next   = ST_SRCH;
            end
            ST_UPD_RD:
            begin
                cmd.upd_rd = 1'b1;
                state_next = ST_UPD_WR;
            end
            ST_UPD_WR:
            begin
                cmd.upd_wr = 1'b1;
                state_next = ST_FIN;
            end
            ST_BLD_RD:
            begin
                cmd.bld_rd = 1'b1;
                state_next = ST_BLD_WR;
            end
            ST_BLD_WR:
            begin
                cmd.bld_wr = 1'b1;
                state_next = stat.bld_last ? ST_FIN : ST_BLD_RD;
            end
            ST_RD_RD:
            begin
                cmd.rd_rd  = 1'b1;
                state_next = ST_RD_RES;
            end
            ST_RD_RES:
            begin
                cmd.rd_res = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/sbd_dp.sv */
// sbd_dp: datapath of the bucket distributor: splitter, count and offset RAMs,
// search bounds, prefix accumulator and output register. Uses sbd_pkg, sbd_ram.
`timescale 1ns / 1ps

module sbd_dp
    import sbd_pkg::*;
#(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic [IN_TDATA_W-1:0]  in_data,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [OUT_TDATA_W-1:0] out_data,
    input  sbd_cmd_t               cmd,
    output sbd_stat_t              stat
);

    localparam int BW     = $clog2(MAX_BUCKETS);
    localparam int NW     = $clog2(MAX_BUCKETS + 1);
    localparam int NSLOTS = MAX_BUCKETS - 1;
    localparam int SAW    = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;

    logic [CFG_W-1:0]      cfg_reg;
    logic [FUNC_W-1:0]     func_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [BW-1:0]         lo_reg, hi_reg, bld_reg, clr_reg;
    logic [COUNT_BITS-1:0] run_reg;
    logic [BKT_W-1:0]      res_bkt_reg, out_bkt_reg;
    logic [OUT32_W-1:0]    res_pos_reg, res_cnt_reg, out_pos_reg, out_cnt_reg;
    logic [KEY_W-1:0]      res_val_reg, out_val_reg;
    logic                  out_valid_reg;

    logic [NW-1:0]         n_act;
    logic [BW-1:0]         n_last, mid;
    logic                  idx_ok, spl_ok;
    logic [KEY_W-1:0]      spl_rdata;
    logic [COUNT_BITS-1:0] cnt_rdata, off_rdata, cnt_inc, off_inc, run_sum;

    logic                  cnt_we, off_we;
    logic [BW-1:0]         cnt_waddr, off_waddr, rd_addr;
    logic [COUNT_BITS-1:0] cnt_wdata, off_wdata;

    // clamp bucket_count to [2, MAX_BUCKETS]
    always_comb
    begin
        if (cfg_reg < CFG_W'(2))
        begin
            n_act = NW'(2);
        end
        else if (32'(cfg_reg) > 32'(MAX_BUCKETS))
        begin
            n_act = NW'(MAX_BUCKETS);
        end
        else
        begin
            n_act = NW'(cfg_reg);
        end
    end

    assign n_last  = BW'(n_act - NW'(1));
    assign mid     = BW'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    assign idx_ok  = (32'(idx_reg) < 32'(MAX_BUCKETS));
    assign spl_ok  = (32'(idx_reg) < 32'(NSLOTS));
    assign cnt_inc = cnt_rdata + COUNT_BITS'(1);
    assign off_inc = off_rdata + COUNT_BITS'(1);
    assign run_sum = run_reg + cnt_rdata;

    assign stat.func      = func_reg;
    assign stat.clr_last  = (32'(clr_reg) == 32'(MAX_BUCKETS - 1));
    assign stat.srch_done = !(lo_reg < hi_reg);
    assign stat.bld_last  = (bld_reg == n_last);
    assign stat.out_free  = !out_valid_reg || out_ready;

    // RAM port steering
    always_comb
    begin
        cnt_we    = cmd.clr_step || (cmd.upd_wr && func_reg == FN_CLASS);
        cnt_waddr = cmd.clr_step ? clr_reg : lo_reg;
        cnt_wdata = cmd.clr_step ? '0 : cnt_inc;
        off_we    = cmd.bld_wr || (cmd.upd_wr && func_reg == FN_SCAT);
        off_waddr = cmd.bld_wr ? bld_reg : lo_reg;
        off_wdata = cmd.bld_wr ? run_reg : off_inc;
        if (cmd.bld_rd)
        begin
            rd_addr = bld_reg;
        end
        else if (cmd.rd_rd)
        begin
            rd_addr = BW'(idx_reg);
        end
        else
        begin
            rd_addr = lo_reg;
        end
    end

    sbd_ram #(.WIDTH(KEY_W), .DEPTH(NSLOTS)) u_spl (
        .clk   (clk),
        .we    (cmd.spl_wr && spl_ok),
        .waddr (SAW'(idx_reg)),
        .wdata (key_reg),
        .raddr (SAW'(mid)),
        .rdata (spl_rdata)
    );

    sbd_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_BUCKETS)) u_cnt (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (rd_addr),
        .rdata (cnt_rdata)
    );

    sbd_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_BUCKETS)) u_off (
        .clk   (clk),
        .we    (off_we),
        .waddr (off_waddr),
        .wdata (off_wdata),
        .raddr (rd_addr),
        .rdata (off_rdata)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= CFG_W'(2);
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg <= cfg_data;
            end
            if (cmd.clr_init)
            begin
                clr_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + BW'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg <= in_data[2:0];
            key_reg  <= in_data[66:3];
            idx_reg  <= in_data[74:67];
        end
        if (cmd.srch_init)
        begin
            lo_reg <= '0;
            hi_reg <= n_last;
        end
        else if (cmd.srch_upd)
        begin
            if ($signed(spl_rdata) <= $signed(key_reg))
            begin
                lo_reg <= mid + BW'(1);
            end
            else
            begin
                hi_reg <= mid;
            end
        end
        if (cmd.bld_init)
        begin
            bld_reg <= '0;
            run_reg <= '0;
        end
        else if (cmd.bld_wr)
        begin
            bld_reg <= bld_reg + BW'(1);
            run_reg <= run_sum;
        end
        if (cmd.upd_wr)
        begin
            res_bkt_reg <= BKT_W'(lo_reg);
            res_val_reg <= (func_reg == FN_SCAT) ? key_reg : '0;
            res_pos_reg <= (func_reg == FN_SCAT) ? OUT32_W'(off_rdata) : '0;
            res_cnt_reg <= (func_reg == FN_CLASS) ? OUT32_W'(cnt_inc) : '0;
        end
        else if (cmd.bld_wr)
        begin
            res_bkt_reg <= '0;
            res_val_reg <= '0;
            res_pos_reg <= '0;
            res_cnt_reg <= OUT32_W'(run_sum);
        end
        else if (cmd.rd_res)
        begin
            res_bkt_reg <= idx_reg;
            res_val_reg <= '0;
            res_pos_reg <= idx_ok ? OUT32_W'(off_rdata) : '0;
            res_cnt_reg <= idx_ok ? OUT32_W'(cnt_rdata) : '0;
        end
        if (cmd.out_load)
        begin
            out_bkt_reg <= res_bkt_reg;
            out_pos_reg <= res_pos_reg;
            out_cnt_reg <= res_cnt_reg;
            out_val_reg <= res_val_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {out_val_reg, out_cnt_reg, out_pos_reg, out_bkt_reg};

endmodule

/* rtl/core/splitter_bucket_distributor_core.sv */
// splitter_bucket_distributor_core: top level of the sample-sort distribution
// engine. Uses sbd_pkg, sbd_ctrl, sbd_dp (and sbd_ram through sbd_dp).
`timescale 1ns / 1ps

// One item at a time. A classify or scatter decodes and captures the item,
// runs a binary search over the splitter RAM, one read and one compare per
// probe (up to ceil(log2(buckets)) probes, eight at 256 buckets), sees that
// the search has closed, then does the count/offset read-modify-write and
// the output load. A build offsets pass walks the active buckets with one
// count RAM read and one offset RAM write each. A read fetches the count and
// offset at its index; a splitter load writes one slot. Clear counts sweeps
// the whole count RAM one entry per cycle; the same sweep runs after reset,
// and no item is taken until it ends. The result sits in an output register,
// so the next item is taken while it waits for m_tready. bucket_count must
// be written only while idle; the block itself does not enforce it.

module splitter_bucket_distributor_core
    import sbd_pkg::*;
#(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // bucket_count register
    input  logic                   cfg_we,
    input  logic [CFG_W-1:0]       cfg_data,
    // input items
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // func[2:0], value[66:3], index[74:67]
    // result items
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // bucket[7:0], position[39:8],
                                              // count[71:40], value_out[135:72]
);

    sbd_cmd_t  cmd;
    sbd_stat_t stat;

    sbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sbd_dp #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

    // an accepted item always keeps the engine busy for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on consecutive cycles");

    // a fresh result only follows a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without work");

    // output register never loads from an idle controller
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !s_tready && stat.out_free)
        else $error("output loaded while idle or full");

endmodule

/* sim/tb_splitter_bucket_distributor_core.sv */
// Testbench for splitter_bucket_distributor_core: drives function items on the input stream,
// predicts every result from its own model of the splitter table, counts and offsets.
// Depends on sbd_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_splitter_bucket_distributor_core;
    import sbd_pkg::*;

    localparam int NBKT = MAX_BUCKETS_DEF;

    typedef struct packed {
        logic [7:0]  index;
        logic [63:0] value;
        logic [2:0]  func;
    } op_t;

    typedef struct packed {
        logic [63:0] value_out;
        logic [31:0] count;
        logic [31:0] position;
        logic [7:0]  bucket;
    } res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    always #5 clk = ~clk;

    splitter_bucket_distributor_core i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // predictor state
    logic [63:0] spl_tab [NBKT-1];
    logic [31:0] cnt_tab [NBKT];
    logic [31:0] off_tab [NBKT];
    int          nbkt_m;          // active bucket count as the model sees it
    int          built_n = 0;     // offsets 0 .. built_n-1 have been built at least once

    op_t  pend_q [$];
    res_t want_q [$];
    int   errors = 0;
    bit   hold_rx = 1'b0;         // long receiver hold-off
    bit   hold_tx = 1'b0;         // sender pause

    function automatic int bucket_of(logic [63:0] key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = nbkt_m - 1;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if ($signed(spl_tab[mid]) <= $signed(key)) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    // apply one accepted item to the model, queue its result if any
    task automatic predict(op_t op);
        res_t r;
        int b;
        logic [31:0] run;
        r = '0;
        case (op.func)
            FN_CLEAR: begin
                for (int i = 0; i < NBKT; i++) cnt_tab[i] = '0;
                return;
            end
            FN_LOAD: begin
                if (op.index < NBKT - 1) spl_tab[op.index] = op.value;
                return;
            end
            FN_CLASS: begin
                b = bucket_of(op.value);
                cnt_tab[b] = cnt_tab[b] + 32'd1;
                r.bucket = 8'(b);
                r.count = cnt_tab[b];
            end
            FN_BUILD: begin
                run = '0;
                for (int i = 0; i < nbkt_m; i++) begin
                    off_tab[i] = run;
                    run = run + cnt_tab[i];
                end
                r.count = run;
            end
            FN_SCAT: begin
                b = bucket_of(op.value);
                r.bucket = 8'(b);
                r.position = off_tab[b];
                off_tab[b] = off_tab[b] + 32'd1;
                r.value_out = op.value;
            end
            FN_READ: begin
                r.bucket = op.index;
                r.position = off_tab[op.index];
                r.count = cnt_tab[op.index];
            end
            default: return;
        endcase
        want_q.push_back(r);
    endtask

    // driver
    int tx_gap = 0;
    always @(posedge clk) begin
        if (s_tvalid && s_tready) begin
            predict(op_t'(s_tdata[74:0]));
            tx_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 14) : 0;
        end
        if (s_tvalid && !s_tready) begin
            // keep offering
        end else if (tx_gap > 0 || hold_tx || pend_q.size() == 0) begin
            if (tx_gap > 0) tx_gap--;
            s_tvalid <= 1'b0;
        end else begin
            s_tvalid <= 1'b1;
            s_tdata <= {5'b0, pend_q.pop_front()};
        end
    end

    // monitor
    int rx_gap = 0;
    always @(posedge clk) begin
        res_t got;
        res_t w;
        if (m_tvalid && m_tready) begin
            got = res_t'(m_tdata);
            if (want_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                w = want_q.pop_front();
                if (got.bucket !== w.bucket)
                    $display("%0t: bucket exp %0d got %0d", $time, w.bucket, got.bucket);
                if (got.position !== w.position)
                    $display("%0t: position exp %0d got %0d", $time, w.position,
                             got.position);
                if (got.count !== w.count)
                    $display("%0t: count exp %0d got %0d", $time, w.count, got.count);
                if (got.value_out !== w.value_out)
                    $display("%0t: value_out exp %h got %h", $time, w.value_out,
                             got.value_out);
                if (got !== w) errors++;
            end
            rx_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 14) : 0;
        end
        if (hold_rx || rx_gap > 0) begin
            if (rx_gap > 0) rx_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog: cycles with no handshake on either side
    int idle_cyc = 0;
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cyc <= 0;
        else idle_cyc <= idle_cyc + 1;
        if (idle_cyc > 20000) begin
            $display("tb_splitter_bucket_distributor_core NOT OK");
            $finish;
        end
    end

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic op_t mk(logic [2:0] f, logic [63:0] v, logic [7:0] ix);
        op_t o;
        o.func = f;
        o.value = v;
        o.index = ix;
        return o;
    endfunction

    // wait for the sender to drain and all results to arrive, then settle
    task automatic drain();
        while (pend_q.size() != 0 || s_tvalid || want_q.size() != 0) @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic set_buckets(int n);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= CFG_W'(n);
        @(posedge clk);
        cfg_we <= 1'b0;
        nbkt_m = n < 2 ? 2 : (n > NBKT ? NBKT : n);
    endtask

    // load a sorted splitter set into the active slots, the only ones a search reads
    task automatic load_sorted(bit narrow);
        logic [63:0] v;
        v = 64'h8000_0000_0000_0000;
        for (int i = 0; i < nbkt_m - 1; i++) begin
            if (narrow) v = v + $urandom_range(0, 4);
            else v = v + {$urandom_range(0, 32'h00ff_ffff), 32'h0};
            if (i == 0 && $urandom_range(0, 1)) v = 64'h8000_0000_0000_0000;
            pend_q.push_back(mk(FN_LOAD, v, 8'(i)));
        end
    endtask

    function automatic logic [63:0] pick_key(bit narrow);
        case ($urandom_range(0, 5))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7fff_ffff_ffff_ffff;
            2: return narrow ? 64'h8000_0000_0000_0000 + $urandom_range(0, 1100) : rnd64();
            default: return narrow ? 64'h8000_0000_0000_0000 + $urandom_range(0, 1100)
                                   : rnd64();
        endcase
    endfunction

    // one sort pass: clear, classify keys, build, scatter them, read buckets back
    task automatic sort_pass(int nkeys, bit narrow);
        logic [63:0] keys [$];
        pend_q.push_back(mk(FN_CLEAR, rnd64(), 8'($urandom)));
        for (int i = 0; i < nkeys; i++) begin
            keys.push_back(pick_key(narrow));
            pend_q.push_back(mk(FN_CLASS, keys[i], 8'($urandom)));
        end
        pend_q.push_back(mk(FN_BUILD, rnd64(), 8'($urandom)));
        if (nbkt_m > built_n) built_n = nbkt_m;
        foreach (keys[i]) begin
            pend_q.push_back(mk(FN_SCAT, keys[i], 8'($urandom)));
            if ($urandom_range(0, 7) == 0)
                pend_q.push_back(mk(FN_READ, rnd64(), 8'($urandom_range(0, nbkt_m - 1))));
            if ($urandom_range(0, 15) == 0)
                pend_q.push_back(mk(3'($urandom_range(6, 7)), rnd64(), 8'($urandom)));
        end
        pend_q.push_back(mk(FN_READ, rnd64(), 8'($urandom_range(0, built_n - 1))));
    endtask

    initial begin
        int sizes [6] = '{2, 256, 3, 17, 0, 511};
        for (int i = 0; i < NBKT; i++) cnt_tab[i] = '0;
        nbkt_m = 2;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (300) @(posedge clk);

        // directed: extreme keys at reset bucket count, loads out of range, unused codes
        load_sorted(1'b0);
        pend_q.push_back(mk(FN_LOAD, 64'h7fff_ffff_ffff_ffff, 8'hff));
        pend_q.push_back(mk(3'd6, rnd64(), 0));
        pend_q.push_back(mk(3'd7, rnd64(), 0));
        pend_q.push_back(mk(FN_CLASS, 64'h8000_0000_0000_0000, 0));
        pend_q.push_back(mk(FN_CLASS, 64'h7fff_ffff_ffff_ffff, 8'hff));
        pend_q.push_back(mk(FN_CLASS, 64'h0, 0));
        pend_q.push_back(mk(FN_BUILD, 0, 0));
        built_n = 2;
        pend_q.push_back(mk(FN_SCAT, 64'hffff_ffff_ffff_ffff, 0));
        pend_q.push_back(mk(FN_SCAT, 64'h7fff_ffff_ffff_ffff, 0));
        pend_q.push_back(mk(FN_READ, 0, 1));
        pend_q.push_back(mk(FN_READ, 0, 0));
        pend_q.push_back(mk(FN_CLEAR, 0, 0));
        pend_q.push_back(mk(FN_READ, 0, 1));
        drain();

        // long receiver hold-off while the sender keeps offering
        hold_rx = 1'b1;
        sort_pass(20, 1'b0);
        repeat (800) @(posedge clk);
        hold_rx = 1'b0;
        drain();

        for (int p = 0; p < 6; p++) begin
            set_buckets(sizes[p]);
            load_sorted(1'(p % 2));
            sort_pass(nbkt_m > 64 ? 20 : 30, 1'(p % 2));
            // sender pause until all results are in, mid phase
            while (pend_q.size() > 30) @(posedge clk);
            hold_tx = 1'b1;
            while (s_tvalid || want_q.size() != 0) @(posedge clk);
            hold_tx = 1'b0;
            drain();
        end

        if (errors == 0) $display("tb_splitter_bucket_distributor_core OK");
        else $display("tb_splitter_bucket_distributor_core NOT OK");
        $finish;
    end

endmodule
